// File: design/hkvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkvt_pkg
// Shared constants, codes and control/status types for the hash key-value
// table.
// ----------------------------------------------------------------------------
package hkvt_pkg;

   // NUM_BUCKETS must be a power of two (bucket = low key bits)
   localparam int NUM_BUCKETS = 256;
   localparam int WAYS        = 4;
   localparam int VALUE_WIDTH = 32;

   localparam int KEY_WIDTH   = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int WIDE_WIDTH  = 64;
   localparam int BUCKET_AW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int WAY_AW      = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef enum logic [1:0] {
      REQ_PUT    = 2'd0,
      REQ_GET    = 2'd1,
      REQ_REMOVE = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_UPDATED  = 3'd0,
      ST_INSERTED = 3'd1,
      ST_DONE     = 3'd2,
      ST_MISSING  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic [WAYS-1:0]                  valid;
      logic [WAYS-1:0][KEY_WIDTH-1:0]   key;
      logic [WAYS-1:0][VALUE_WIDTH-1:0] value;
   } row_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

// File: design/hkvt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkvt_ctrl
// Request sequencer: takes a request, waits for the registered bucket row
// read, then commits once the result register can take the answer.
// ----------------------------------------------------------------------------
module hkvt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hkvt_pkg::sts_type sts,
   output hkvt_pkg::cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_LOOKUP
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      accept;

   assign accept      = req_valid && !req_stall_ff;
   assign req_stall   = req_stall_ff;
   assign cmd.capture = accept;
   assign cmd.commit  = (state_ff == S_LOOKUP) && !sts.out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff     <= S_LOOKUP;
                  req_stall_ff <= 1'b1;
               end
            end
            S_LOOKUP: begin
               if (!sts.out_busy) begin
                  state_ff     <= S_IDLE;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_stall_ff <= 1'b0;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOKUP) && req_stall_ff)
      else $error("accepted transfer did not start a lookup");

   a_hold_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP) && sts.out_busy |=> (state_ff == S_LOOKUP))
      else $error("lookup left while result register busy");
`endif

endmodule

// File: design/hkvt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkvt_datapath
// Bucket row memory, per-row written flags, parallel way compare, row
// update and result register.
// ----------------------------------------------------------------------------
module hkvt_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hkvt_pkg::cmd_type                     cmd,
   output hkvt_pkg::sts_type                     sts,
   input  logic [1:0]                           req_type,
   input  logic [hkvt_pkg::KEY_WIDTH-1:0]        req_key,
   input  logic [hkvt_pkg::DATA_WIDTH-1:0]       req_value_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_status,
   output logic                                 rsp_hit,
   output logic [hkvt_pkg::DATA_WIDTH-1:0]       rsp_value_out
);

   hkvt_pkg::row_type                          bucket_mem_ff [hkvt_pkg::NUM_BUCKETS];
   logic [hkvt_pkg::NUM_BUCKETS-1:0]           row_written_ff;

   hkvt_pkg::row_type                          rd_row_ff;
   logic                                       rd_written_ff;
   logic [1:0]                                 kind_ff;
   logic [hkvt_pkg::KEY_WIDTH-1:0]             key_ff;
   logic [hkvt_pkg::VALUE_WIDTH-1:0]           value_ff;
   logic [hkvt_pkg::BUCKET_AW-1:0]             bucket_ff;

   logic                                       out_valid_ff;
   hkvt_pkg::status_type                       status_ff;
   logic                                       hit_ff;
   logic [hkvt_pkg::DATA_WIDTH-1:0]            value_out_ff;

   logic [hkvt_pkg::BUCKET_AW-1:0]             bucket_in;
   logic [hkvt_pkg::WAYS-1:0]                  ways_valid;
   logic [hkvt_pkg::WAYS-1:0]                  match_vec;
   logic [hkvt_pkg::WAY_AW-1:0]                match_idx;
   logic [hkvt_pkg::WAY_AW-1:0]                free_idx;
   logic                                       match_any;
   logic                                       free_any;
   logic [hkvt_pkg::WIDE_WIDTH-1:0]            stored_wide;
   hkvt_pkg::row_type                          row_in;
   hkvt_pkg::status_type                       status_in;
   logic                                       hit_in;
   logic [hkvt_pkg::DATA_WIDTH-1:0]            value_out_in;

   assign bucket_in = req_key[hkvt_pkg::BUCKET_AW-1:0];

   // bucket row read on acceptance, write-back on commit
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_row_ff <= bucket_mem_ff[bucket_in];
         kind_ff   <= req_type;
         key_ff    <= req_key;
         value_ff  <= hkvt_pkg::VALUE_WIDTH'(hkvt_pkg::WIDE_WIDTH'(req_value_in));
         bucket_ff <= bucket_in;
      end
      if (cmd.commit) begin
         bucket_mem_ff[bucket_ff] <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_written_ff <= '0;
         rd_written_ff  <= 1'b0;
      end else begin
         if (cmd.capture) begin
            rd_written_ff <= row_written_ff[bucket_in];
         end
         if (cmd.commit) begin
            row_written_ff[bucket_ff] <= 1'b1;
         end
      end
   end

   // never-written rows read as empty
   assign ways_valid = rd_written_ff ? rd_row_ff.valid : '0;

   always_comb begin
      for (int w = 0; w < hkvt_pkg::WAYS; w++) begin
         match_vec[w] = ways_valid[w] && (rd_row_ff.key[w] == key_ff);
      end
   end

   assign match_any = |match_vec;
   assign free_any  = ~&ways_valid;

   // lowest matching and lowest free way
   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int w = hkvt_pkg::WAYS - 1; w >= 0; w--) begin
         if (match_vec[w]) begin
            match_idx = hkvt_pkg::WAY_AW'(w);
         end
         if (!ways_valid[w]) begin
            free_idx = hkvt_pkg::WAY_AW'(w);
         end
      end
   end

   assign stored_wide = hkvt_pkg::WIDE_WIDTH'(rd_row_ff.value[match_idx]);

   always_comb begin
      row_in       = rd_row_ff;
      row_in.valid = ways_valid;
      status_in    = hkvt_pkg::ST_MISSING;
      hit_in       = 1'b0;
      value_out_in = '0;
      unique case (kind_ff)
         hkvt_pkg::REQ_PUT: begin
            if (match_any) begin
               row_in.value[match_idx] = value_ff;
               status_in               = hkvt_pkg::ST_UPDATED;
               hit_in                  = 1'b1;
            end else if (free_any) begin
               row_in.valid[free_idx] = 1'b1;
               row_in.key[free_idx]   = key_ff;
               row_in.value[free_idx] = value_ff;
               status_in              = hkvt_pkg::ST_INSERTED;
            end else begin
               status_in = hkvt_pkg::ST_FULL;
            end
         end
         hkvt_pkg::REQ_GET: begin
            if (match_any) begin
               status_in    = hkvt_pkg::ST_DONE;
               hit_in       = 1'b1;
               value_out_in = stored_wide[hkvt_pkg::DATA_WIDTH-1:0];
            end
         end
         hkvt_pkg::REQ_REMOVE: begin
            if (match_any) begin
               row_in.valid[match_idx] = 1'b0;
               status_in               = hkvt_pkg::ST_DONE;
               hit_in                  = 1'b1;
            end
         end
         default: begin
            status_in = hkvt_pkg::ST_MISSING;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff    <= status_in;
         hit_ff       <= hit_in;
         value_out_ff <= value_out_in;
      end
   end

   assign sts.out_busy  = out_valid_ff && rsp_stall;
   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_hit       = hit_ff;
   assign rsp_value_out = value_out_ff;

`ifndef SYNTH
   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(cmd.commit))
      else $error("result appeared without a commit");

   a_value_needs_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (value_out_in != '0) |-> hit_in && (kind_ff == hkvt_pkg::REQ_GET))
      else $error("non-zero value returned without a get hit");
`endif

endmodule

// File: design/hash_key_value_table_top.sv
`timescale 1ns / 1ps
// The request transfer captures the bucket row; the result register is loaded
// at commit. No new request is taken until that commit: the row read is followed
// by the compare-and-write-back on the single-port row memory.
// A held result stalls the next commit but not a transfer into an idle sequencer.
// Reset (synchronous) clears control state and the per-bucket written flags,
// so the table reads empty immediately; there is no clearing pass.
// ----------------------------------------------------------------------------
// hash_key_value_table_top
// Hash key-value table with modulo buckets and a fixed number of ways per
// bucket: put, get and remove of 32-bit keys.
// ----------------------------------------------------------------------------
module hash_key_value_table_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_type,
   input  logic [hkvt_pkg::KEY_WIDTH-1:0]  req_key,
   input  logic [hkvt_pkg::DATA_WIDTH-1:0] req_value_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_status,
   output logic                           rsp_hit,
   output logic [hkvt_pkg::DATA_WIDTH-1:0] rsp_value_out
);

   hkvt_pkg::cmd_type cmd;
   hkvt_pkg::sts_type sts;

   hkvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   hkvt_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_type      (req_type),
      .req_key       (req_key),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_hit       (rsp_hit),
      .rsp_value_out (rsp_value_out)
   );

endmodule
